### rtl/ppbf_pkg.sv
// Package: shared widths, limits, register indexes and stage types for the projection filter.
`default_nettype none
package ppbf_pkg;

   localparam int COORD_WIDTH    = 32;
   localparam int FRAC_BITS      = 16;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int FOCAL_WIDTH    = 31;
   localparam int CFG_WIDTH      = 32;
   localparam int DIFF_WIDTH     = CFG_WIDTH + 1;
   localparam int PROD_WIDTH     = DIFF_WIDTH + COORD_WIDTH;
   localparam int LIM_WIDTH      =
      ((COORD_WIDTH > FRAC_BITS + 8) ? COORD_WIDTH : FRAC_BITS + 8) + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [CFG_WIDTH-1:0]   cfg_value_type;
   typedef logic        [FOCAL_WIDTH-1:0] focal_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [LIM_WIDTH-1:0]   lim_type;

   // depth and lateral limits in metres, fixed point
   localparam lim_type Z_MAX = lim_type'(60 * (2 ** FRAC_BITS));
   localparam lim_type X_MAX = lim_type'(80 * (2 ** FRAC_BITS));
   localparam lim_type X_MIN = -X_MAX;
   localparam lim_type Y_MAX = lim_type'(40 * (2 ** FRAC_BITS));
   localparam lim_type Y_MIN = -Y_MAX;

   typedef enum logic [2:0] {
      REG_FOCAL_X   = 3'd0,
      REG_FOCAL_Y   = 3'd1,
      REG_CENTRE_U  = 3'd2,
      REG_CENTRE_V  = 3'd3,
      REG_BOX_U_MIN = 3'd4,
      REG_BOX_U_MAX = 3'd5,
      REG_BOX_V_MIN = 3'd6,
      REG_BOX_V_MAX = 3'd7
   } reg_index_type;

   typedef struct packed {
      focal_type     focal_x;
      focal_type     focal_y;
      cfg_value_type centre_u;
      cfg_value_type centre_v;
      cfg_value_type box_u_min;
      cfg_value_type box_u_max;
      cfg_value_type box_v_min;
      cfg_value_type box_v_max;
   } cfg_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      point_type point;
      diff_type  du_lo;
      diff_type  du_hi;
      diff_type  dv_lo;
      diff_type  dv_hi;
   } screen_type;

   typedef struct packed {
      point_type point;
      prod_type  num_u;
      prod_type  lo_u;
      prod_type  hi_u;
      prod_type  num_v;
      prod_type  lo_v;
      prod_type  hi_v;
   } mult_type;

endpackage
`default_nettype wire

### rtl/ppbf_csr.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module ppbf_csr (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [ppbf_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  wire logic [ppbf_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic      [ppbf_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                        csr_pready,
   output ppbf_pkg::cfg_type                           cfg
);
   import ppbf_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign write      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (index)
            REG_FOCAL_X:   cfg_in.focal_x   = csr_pwdata[FOCAL_WIDTH-1:0];
            REG_FOCAL_Y:   cfg_in.focal_y   = csr_pwdata[FOCAL_WIDTH-1:0];
            REG_CENTRE_U:  cfg_in.centre_u  = csr_pwdata;
            REG_CENTRE_V:  cfg_in.centre_v  = csr_pwdata;
            REG_BOX_U_MIN: cfg_in.box_u_min = csr_pwdata;
            REG_BOX_U_MAX: cfg_in.box_u_max = csr_pwdata;
            REG_BOX_V_MIN: cfg_in.box_v_min = csr_pwdata;
            REG_BOX_V_MAX: cfg_in.box_v_max = csr_pwdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_FOCAL_X:   csr_prdata = CSR_DATA_WIDTH'(cfg_ff.focal_x);
         REG_FOCAL_Y:   csr_prdata = CSR_DATA_WIDTH'(cfg_ff.focal_y);
         REG_CENTRE_U:  csr_prdata = cfg_ff.centre_u;
         REG_CENTRE_V:  csr_prdata = cfg_ff.centre_v;
         REG_BOX_U_MIN: csr_prdata = cfg_ff.box_u_min;
         REG_BOX_U_MAX: csr_prdata = cfg_ff.box_u_max;
         REG_BOX_V_MIN: csr_prdata = cfg_ff.box_v_min;
         REG_BOX_V_MAX: csr_prdata = cfg_ff.box_v_max;
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

### rtl/ppbf_screen.sv
// Stage one: range screen of the point and box edges relative to the centre.
`default_nettype none
module ppbf_screen (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire ppbf_pkg::point_type    in_point,
   input  wire ppbf_pkg::cfg_type      cfg,
   output logic                        out_valid,
   output ppbf_pkg::screen_type        out_data
);
   import ppbf_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   screen_type data_ff;
   screen_type data_in;
   lim_type    x_ext;
   lim_type    y_ext;
   lim_type    z_ext;
   logic       in_range;

   assign x_ext = lim_type'(in_point.x);
   assign y_ext = lim_type'(in_point.y);
   assign z_ext = lim_type'(in_point.z);

   assign in_range = (z_ext > 0) && (z_ext <= Z_MAX)
                  && (x_ext <= X_MAX) && (x_ext >= X_MIN)
                  && (y_ext <= Y_MAX) && (y_ext >= Y_MIN);

   // out-of-range points are dropped here and never enter the pipe
   assign valid_in = in_valid && in_range;

   always_comb begin
      data_in.point = in_point;
      data_in.du_lo = diff_type'(cfg.box_u_min) - diff_type'(cfg.centre_u);
      data_in.du_hi = diff_type'(cfg.box_u_max) - diff_type'(cfg.centre_u);
      data_in.dv_lo = diff_type'(cfg.box_v_min) - diff_type'(cfg.centre_v);
      data_in.dv_hi = diff_type'(cfg.box_v_max) - diff_type'(cfg.centre_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && valid_in) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

### rtl/ppbf_mult.sv
// Stage two: projection numerators and cross-multiplied box edges.
`default_nettype none
module ppbf_mult (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire ppbf_pkg::screen_type   in_data,
   input  wire ppbf_pkg::cfg_type      cfg,
   output logic                        out_valid,
   output ppbf_pkg::mult_type          out_data
);
   import ppbf_pkg::*;

   logic     valid_ff;
   mult_type data_ff;
   mult_type data_in;
   prod_type fx;
   prod_type fy;
   prod_type z;

   assign fx = prod_type'(signed'({1'b0, cfg.focal_x}));
   assign fy = prod_type'(signed'({1'b0, cfg.focal_y}));
   assign z  = prod_type'(in_data.point.z);

   // z > 0 here, so each edge test is f*c against (edge - centre)*z
   always_comb begin
      data_in.point = in_data.point;
      data_in.num_u = fx * prod_type'(in_data.point.x);
      data_in.lo_u  = prod_type'(in_data.du_lo) * z;
      data_in.hi_u  = prod_type'(in_data.du_hi) * z;
      data_in.num_v = fy * prod_type'(in_data.point.y);
      data_in.lo_v  = prod_type'(in_data.dv_lo) * z;
      data_in.hi_v  = prod_type'(in_data.dv_hi) * z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

### rtl/ppbf_test.sv
// Stage three: box edge compares and the output register.
`default_nettype none
module ppbf_test (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire ppbf_pkg::mult_type     in_data,
   output logic                        out_valid,
   output ppbf_pkg::point_type         out_point
);
   import ppbf_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   point_type point_ff;
   logic      inside_u;
   logic      inside_v;

   assign inside_u = (in_data.num_u >= in_data.lo_u) && (in_data.num_u <= in_data.hi_u);
   assign inside_v = (in_data.num_v >= in_data.lo_v) && (in_data.num_v <= in_data.hi_v);
   assign valid_in = in_valid && inside_u && inside_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && valid_in) begin
         point_ff <= in_data.point;
      end
   end

   assign out_valid = valid_ff;
   assign out_point = point_ff;

endmodule
`default_nettype wire

### rtl/point_projection_bbox_filter.sv
// Top level: pinhole projection point filter with pixel box test.
// Requests carry one camera-frame point (x, y, z, signed fixed point, metres)
// on req_valid / req_stall. A point with z <= 0, z > 60, |x| > 80 or |y| > 40
// is dropped; otherwise it is projected with the focal lengths and centre and
// passed on unchanged on rsp_valid / rsp_stall only if it lands inside the
// inclusive pixel box. Rejected points produce no response.
// The user must write configuration through the csr_ port only while no
// request is in flight; the block does not enforce this. pready is always
// high and reads return the register value. A point passes through three
// register stages: range screen, multiplier stage, compare stage into the
// output register.
// One request is accepted every cycle; the multiplier stage is fully
// pipelined, so rate is set by the downstream stall alone.
// When rsp_stall is high the stages behind the output register keep filling
// bubbles; req_stall rises only once every stage holds a point.
// Reset clears all configuration registers to zero and empties the pipe.
`default_nettype none
module point_projection_bbox_filter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire ppbf_pkg::coord_type                 req_point_x,
   input  wire ppbf_pkg::coord_type                 req_point_y,
   input  wire ppbf_pkg::coord_type                 req_point_z,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ppbf_pkg::coord_type                      rsp_out_x,
   output ppbf_pkg::coord_type                      rsp_out_y,
   output ppbf_pkg::coord_type                      rsp_out_z,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [ppbf_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [ppbf_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [ppbf_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                     csr_pready
);
   import ppbf_pkg::*;

   cfg_type    cfg;
   point_type  req_point;
   point_type  rsp_point;
   screen_type s1_data;
   mult_type   s2_data;
   logic       s1_valid;
   logic       s2_valid;
   logic       out_adv;
   logic       s2_adv;
   logic       s1_adv;

   assign req_point.x = req_point_x;
   assign req_point.y = req_point_y;
   assign req_point.z = req_point_z;

   assign out_adv   = !rsp_valid || !rsp_stall;
   assign s2_adv    = !s2_valid || out_adv;
   assign s1_adv    = !s1_valid || s2_adv;
   assign req_stall = !s1_adv;

   ppbf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ppbf_screen u_screen (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_adv),
      .in_valid  (req_valid),
      .in_point  (req_point),
      .cfg       (cfg),
      .out_valid (s1_valid),
      .out_data  (s1_data)
   );

   ppbf_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .advance   (s2_adv),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .cfg       (cfg),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   ppbf_test u_test (
      .clock     (clock),
      .reset     (reset),
      .advance   (out_adv),
      .in_valid  (s2_valid),
      .in_data   (s2_data),
      .out_valid (rsp_valid),
      .out_point (rsp_point)
   );

   assign rsp_out_x = rsp_point.x;
   assign rsp_out_y = rsp_point.y;
   assign rsp_out_z = rsp_point.z;

endmodule
`default_nettype wire

### rtl/ppbf_checker.sv
// Port-level checker for the projection filter, bound to the top level.
`default_nettype none
module ppbf_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire ppbf_pkg::coord_type                 req_point_x,
   input wire ppbf_pkg::coord_type                 req_point_y,
   input wire ppbf_pkg::coord_type                 req_point_z,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire ppbf_pkg::coord_type                 rsp_out_x,
   input wire ppbf_pkg::coord_type                 rsp_out_y,
   input wire ppbf_pkg::coord_type                 rsp_out_z,
   input wire logic                                csr_psel,
   input wire logic                                csr_penable,
   input wire logic                                csr_pwrite,
   input wire logic [ppbf_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input wire logic [ppbf_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input wire logic [ppbf_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   input wire logic                                csr_pready
);
   import ppbf_pkg::*;

   logic csr_write;
   logic req_accept;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_accept = req_valid && !req_stall;

   // pipe empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_z))
      else $error("stalled response changed");

   // back-pressure only when the output holds a stalled response
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with room in the pipe");

   // a point behind the camera never produces a response
   a_drop_behind: assert property (@(posedge clock) disable iff (reset)
      req_accept && !(req_point_z > 0) && !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         |=> !rsp_valid)
      else $error("response for a point with non-positive depth");

   // box_u_min register read back returns the value just written
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_write && (csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_BOX_U_MIN)
         ##1 (csr_paddr == $past(csr_paddr)) |-> csr_prdata == $past(csr_pwdata))
      else $error("box register read back mismatch");

endmodule

bind point_projection_bbox_filter ppbf_checker u_ppbf_checker (.*);
`default_nettype wire
